FILE: sv/mrc_pkg.sv
// ----------------------------------------------------------------------------
// mrc_pkg: shared types and constants for the Modbus RTU response checker
// Holds the CRC-16 byte step, status and function codes, register indexes
// and the structs passed between the frame tracker and the verdict stage.
// ----------------------------------------------------------------------------
package mrc_pkg;

    localparam int DATA_BYTES_DEF = 8;
    localparam int VALUE_W        = 64;
    localparam int STATUS_W       = 3;
    localparam int EXC_W          = 8;
    localparam int REG_COUNT_W    = 3;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 8;
    localparam int IN_TDATA_W     = 8;
    localparam int OUT_FIELDS_W   = STATUS_W + EXC_W + VALUE_W;
    localparam int OUT_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_LSB  = 16'h0001;
    localparam logic [7:0]  EXC_FLAG = 8'h80;

    localparam logic [7:0] POS_MAX       = 8'd255;
    localparam logic [7:0] MIN_FRAME_LEN = 8'd5;
    localparam logic [7:0] POS_SLAVE     = 8'd0;
    localparam logic [7:0] POS_FUNCTION  = 8'd1;
    localparam logic [7:0] POS_COUNT     = 8'd2;
    localparam logic [7:0] POS_DATA      = 8'd3;

    localparam logic [7:0] FUNC_READ_HOLDING = 8'd3;
    localparam logic [7:0] FUNC_READ_INPUT   = 8'd4;
    localparam logic [7:0] FUNC_PRESET_MULTI = 8'd16;

    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SLAVE_ID  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_FUNCTION  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_REG_COUNT = 2'd2;

    localparam logic [7:0]             RST_SLAVE_ID  = 8'd1;
    localparam logic [7:0]             RST_FUNCTION  = 8'd3;
    localparam logic [REG_COUNT_W-1:0] RST_REG_COUNT = 3'd2;

    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t ST_VALID        = 3'd0;
    localparam status_t ST_SHORT        = 3'd1;
    localparam status_t ST_BAD_ID       = 3'd2;
    localparam status_t ST_CRC          = 3'd3;
    localparam status_t ST_EXCEPTION    = 3'd4;
    localparam status_t ST_BAD_FUNCTION = 3'd5;
    localparam status_t ST_BAD_COUNT    = 3'd6;

    typedef struct packed {
        logic [7:0]             expected_slave_id;
        logic [7:0]             expected_function;
        logic [REG_COUNT_W-1:0] register_count;
    } cfg_t;

    // Frame state as it stands once the current byte is folded in
    typedef struct packed {
        logic [7:0]         position;
        logic [15:0]        crc;
        logic [7:0]         slave_byte;
        logic [7:0]         function_byte;
        logic [7:0]         count_byte;
        logic [VALUE_W-1:0] data;
    } frame_t;

    // One byte of the reflected CRC-16, eight bit steps unrolled
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data_in);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data_in};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_LSB) != 16'h0000) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: sv/modbus_rtu_response_checker_core.sv
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker_core: Modbus RTU response frame checker
// Takes a response one byte per word, runs CRC-16 and the header checks,
// and gives one verdict word per frame.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one received byte per word; tlast marks the frame's last
//   byte. Every byte goes into an input register; the frame tracker then folds it
//   into the frame state (position, CRC-16, slave/function/count bytes,
//   big-endian data). On the last byte the ranked checks fill the result
//   register, which m_axis presents: status, exception code and value.
//   The cfg channel writes expected slave id (index 0), expected function
//   (index 1) and register count (index 2); cfg_ready is always high and
//   the registers should change only while no frame is in flight.
// Flow:
//   One byte per cycle while m_axis does not stall a pending last byte.
//   A last byte waits in the input register until the result register
//   has room, and its verdict is then judged into the result register.
//   The byte step is the CRC unrolled over 8 bits.
// Reset and stall:
//   aresetn (synchronous, low) empties both registers, clears the frame and
//   restores the register defaults (id 1, function 3, count 2). While
//   m_axis stalls with a verdict held, data bytes keep flowing; only a
//   further last byte waits in the input register and s_axis_tready drops.
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker_core import mrc_pkg::*; #(
    parameter int DATA_BYTES = DATA_BYTES_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input byte stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic                   s_axis_tlast,   // last_byte
    // verdict stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [2:0] status, [10:3] exception_code,
                                                   // [74:11] value, [79:75] zero
    // register writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Configuration registers
    logic [7:0]             slave_id_reg;
    logic [7:0]             function_reg;
    logic [REG_COUNT_W-1:0] reg_count_reg;
    cfg_t                   cfg;

    // Input register
    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_last_reg;
    logic                   advance;
    logic                   s_accept;

    frame_t                 frame_next;
    status_t                out_status;
    logic [EXC_W-1:0]       out_exc;
    logic [VALUE_W-1:0]     out_value;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_id_reg  <= RST_SLAVE_ID;
            function_reg  <= RST_FUNCTION;
            reg_count_reg <= RST_REG_COUNT;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_IDX_SLAVE_ID:  slave_id_reg  <= cfg_data;
                CFG_IDX_FUNCTION:  function_reg  <= cfg_data;
                CFG_IDX_REG_COUNT: reg_count_reg <= cfg_data[REG_COUNT_W-1:0];
                default: ;  // unmapped index: ignore
            endcase
        end
    end

    assign cfg = '{
        expected_slave_id: slave_id_reg,
        expected_function: function_reg,
        register_count:    reg_count_reg
    };

    // A data byte always moves on; a last byte needs room in the result register
    assign advance       = in_valid_reg && (!in_last_reg || !m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // Hold the payload until the word is accepted
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_axis_tdata[7:0];
            in_last_reg <= s_axis_tlast;
        end
    end

    mrc_frame_track #(
        .DATA_BYTES (DATA_BYTES)
    ) u_track (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .rx_byte    (in_byte_reg),
        .last_byte  (in_last_reg),
        .frame_next (frame_next)
    );

    mrc_verdict u_verdict (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (advance && in_last_reg),
        .frame          (frame_next),
        .cfg            (cfg),
        .out_ready      (m_axis_tready),
        .out_valid      (m_axis_tvalid),
        .status         (out_status),
        .exception_code (out_exc),
        .value          (out_value)
    );

    assign m_axis_tdata = OUT_TDATA_W'({out_value, out_exc, out_status});

endmodule

FILE: sv/mrc_frame_track.sv
// ----------------------------------------------------------------------------
// mrc_frame_track: per-frame byte position, CRC and header/data capture
// Folds one byte per step into the frame state and clears it after the
// marked last byte.
// ----------------------------------------------------------------------------
module mrc_frame_track import mrc_pkg::*; #(
    parameter int DATA_BYTES = DATA_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] rx_byte,
    input  logic       last_byte,
    output frame_t     frame_next
);

    localparam int SHIFT_W = DATA_BYTES * 8;

    logic [7:0]         position_reg, position_next;
    logic [15:0]        crc_reg, crc_next;
    logic [7:0]         slave_reg, slave_next;
    logic [7:0]         function_reg, function_next;
    logic [7:0]         count_reg, count_next;
    logic [SHIFT_W-1:0] shift_reg, shift_next;
    logic [7:0]         data_index;
    logic               capture;

    always_comb begin
        position_next = (position_reg != POS_MAX) ? position_reg + 8'd1 : position_reg;
        crc_next      = crc16_byte(crc_reg, rx_byte);
        slave_next    = slave_reg;
        function_next = function_reg;
        count_next    = count_reg;
        shift_next    = shift_reg;
        data_index    = position_reg - POS_DATA;
        capture       = (position_reg >= POS_DATA) && (data_index < count_reg)
                        && (data_index < 8'(DATA_BYTES));
        case (position_reg)
            POS_SLAVE:    slave_next    = rx_byte;
            POS_FUNCTION: function_next = rx_byte;
            POS_COUNT:    count_next    = rx_byte;
            default: begin
                if (capture) begin
                    shift_next = {shift_reg[SHIFT_W-9:0], rx_byte};
                end
            end
        endcase
    end

    assign frame_next = '{
        position:      position_next,
        crc:           crc_next,
        slave_byte:    slave_next,
        function_byte: function_next,
        count_byte:    count_next,
        data:          VALUE_W'(shift_next)
    };

    // Drop the frame state after the last byte so the next frame starts clean
    always_ff @(posedge aclk) begin
        if (!aresetn || (step && last_byte)) begin
            position_reg <= '0;
            crc_reg      <= CRC_INIT;
            slave_reg    <= '0;
            function_reg <= '0;
            count_reg    <= '0;
            shift_reg    <= '0;
        end else if (step) begin
            position_reg <= position_next;
            crc_reg      <= crc_next;
            slave_reg    <= slave_next;
            function_reg <= function_next;
            count_reg    <= count_next;
            shift_reg    <= shift_next;
        end
    end

endmodule

FILE: sv/mrc_verdict.sv
// ----------------------------------------------------------------------------
// mrc_verdict: ordered frame checks and result register
// Ranks the checks, picks the exception code and value, and holds the
// result until the receiver takes it.
// ----------------------------------------------------------------------------
module mrc_verdict import mrc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  frame_t             frame,
    input  cfg_t               cfg,
    input  logic               out_ready,
    output logic               out_valid,
    output status_t            status,
    output logic [EXC_W-1:0]   exception_code,
    output logic [VALUE_W-1:0] value
);

    logic               valid_reg, valid_next;
    status_t            status_reg, status_next;
    logic [EXC_W-1:0]   exc_reg, exc_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [7:0]         expected_count;

    assign expected_count = 8'({cfg.register_count, 1'b0});

    always_comb begin
        exc_next   = '0;
        value_next = '0;
        if (frame.position < MIN_FRAME_LEN) begin
            status_next = ST_SHORT;
        end else if (frame.slave_byte != cfg.expected_slave_id) begin
            status_next = ST_BAD_ID;
        end else if (frame.crc != 16'h0000) begin
            status_next = ST_CRC;
        end else if ((frame.function_byte & EXC_FLAG) != 8'h00) begin
            status_next = ST_EXCEPTION;
            exc_next    = frame.count_byte;
        end else if (frame.function_byte != cfg.expected_function) begin
            status_next = ST_BAD_FUNCTION;
        end else if (frame.function_byte inside {FUNC_READ_HOLDING, FUNC_READ_INPUT}) begin
            if (frame.count_byte == expected_count) begin
                status_next = ST_VALID;
                value_next  = frame.data;
            end else begin
                status_next = ST_BAD_COUNT;
            end
        end else if (frame.function_byte == FUNC_PRESET_MULTI) begin
            status_next = ST_VALID;
        end else begin
            status_next = ST_BAD_FUNCTION;
        end
    end

    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            status_reg <= status_next;
            exc_reg    <= exc_next;
            value_reg  <= value_next;
        end
    end

    assign out_valid      = valid_reg;
    assign status         = status_reg;
    assign exception_code = exc_reg;
    assign value          = value_reg;

endmodule

FILE: sv/mrc_checker.sv
// ----------------------------------------------------------------------------
// mrc_checker: port-level checks for the response checker
// Watches the verdict stream for held words and consistent field contents.
// ----------------------------------------------------------------------------
module mrc_checker import mrc_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    status_t st;
    assign st = m_axis_tdata[STATUS_W-1:0];

    // A stalled verdict holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("verdict changed while stalled");

    // Status stays within the defined codes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> st <= ST_BAD_COUNT)
        else $error("undefined status code");

    // Exception code only rides with an exception verdict
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && st != ST_EXCEPTION
            |-> m_axis_tdata[STATUS_W+EXC_W-1:STATUS_W] == '0)
        else $error("exception code set without exception status");

    // Value and padding stay zero unless the verdict is valid
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && st != ST_VALID
            |-> m_axis_tdata[OUT_TDATA_W-1:STATUS_W+EXC_W] == '0)
        else $error("value set on a failed frame");

endmodule

bind modbus_rtu_response_checker_core mrc_checker u_mrc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
